FILE: rtl/indexed_product_scatter_accumulate_core_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the indexed product scatter accumulate core
// all macros sample on clk_i and are disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef INDEXED_PRODUCT_SCATTER_ACCUMULATE_CORE_MACROS_SVH
`define INDEXED_PRODUCT_SCATTER_ACCUMULATE_CORE_MACROS_SVH

// same-cycle implication
`define IPSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ipsa: assertion failed");

// next-cycle implication
`define IPSA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ipsa: assertion failed");

`endif

FILE: rtl/ipsa_pkg.sv
// ----------------------------------------------------------------------------
// ipsa_pkg
// shared types, store sizes and helpers of the scatter accumulate core
// ----------------------------------------------------------------------------
package ipsa_pkg;

  localparam int VECTOR_DEPTH = 1024;
  localparam int RESULT_DEPTH = 1024;

  localparam int IdxW = 10;
  localparam int ValW = 32;
  localparam int AccW = 48;
  localparam int VecAw = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int ResAw = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic signed [ValW-1:0] val_t;
  typedef logic signed [AccW-1:0] acc_t;
  typedef logic signed [2*ValW-1:0] prod_t;
  typedef logic [VecAw-1:0] vec_addr_t;
  typedef logic [ResAw-1:0] res_addr_t;

  typedef enum logic [2:0] {
    MODE_LOAD_FIRST  = 3'd0,
    MODE_LOAD_SECOND = 3'd1,
    MODE_ACCUMULATE  = 3'd2,
    MODE_READ        = 3'd3,
    MODE_CLEAR       = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_WB
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic      capture;
    logic      mul;
    logic      wb;
    logic      clr;
    res_addr_t clr_addr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } status_t;

  localparam acc_t AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam acc_t AccMin = {1'b1, {(AccW-1){1'b0}}};

  function automatic logic vec_in_range(idx_t idx);
    return int'(idx) < VECTOR_DEPTH;
  endfunction

  function automatic logic res_in_range(idx_t idx);
    return int'(idx) < RESULT_DEPTH;
  endfunction

endpackage

FILE: rtl/ipsa_ctrl.sv
// ----------------------------------------------------------------------------
// ipsa_ctrl
// sequencer: clearing pass after reset, then accept / multiply / write back
// ----------------------------------------------------------------------------
`include "indexed_product_scatter_accumulate_core_macros.svh"

module ipsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ipsa_pkg::status_t status_i,
  output ipsa_pkg::cmd_t    cmd_o
);
  import ipsa_pkg::*;

  localparam res_addr_t ClrLast = ResAw'(RESULT_DEPTH - 1);

  state_e    state_q, state_d;
  res_addr_t clr_cnt_q, clr_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    clr_cnt_d      = clr_cnt_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.clr_addr = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ClrLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_WB;
      end
      ST_WB: begin
        // hold until the output register can take the word
        if (!status_i.out_busy) begin
          cmd_o.wb = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `IPSA_ASSERT_IMP(a_clear_runs_full, (state_q == ST_CLEAR && state_d != ST_CLEAR), (clr_cnt_q == ClrLast))
  `IPSA_ASSERT_NXT(a_accept_to_mul, (in_valid_i && in_ready_o), (state_q == ST_MUL && !in_ready_o))
  `IPSA_ASSERT_NXT(a_wb_completes, (state_q == ST_WB && !status_i.out_busy), (state_q == ST_IDLE))

endmodule

FILE: rtl/ipsa_datapath.sv
// ----------------------------------------------------------------------------
// ipsa_datapath
// operand and accumulator stores, multiplier, saturating add, output register
// ----------------------------------------------------------------------------
module ipsa_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipsa_pkg::cmd_t    cmd_i,
  output ipsa_pkg::status_t status_o,
  input  ipsa_pkg::mode_e   mode_i,
  input  ipsa_pkg::idx_t    first_index_i,
  input  ipsa_pkg::idx_t    second_index_i,
  input  ipsa_pkg::idx_t    target_index_i,
  input  ipsa_pkg::val_t    load_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ipsa_pkg::acc_t    read_value_o,
  output logic              range_error_o,
  output logic              saturated_o
);
  import ipsa_pkg::*;

  val_t first_mem  [VECTOR_DEPTH];
  val_t second_mem [VECTOR_DEPTH];
  acc_t acc_mem    [RESULT_DEPTH];

  mode_e mode_q;
  idx_t  ia_q, ib_q, ic_q;
  val_t  val_q;
  val_t  first_rd_q, second_rd_q;
  acc_t  acc_rd_q;
  prod_t prod_q;

  logic  out_valid_q;
  acc_t  out_value_q;
  logic  out_err_q, out_sat_q;

  acc_t            prod_shift;
  logic [AccW:0]   sum_wide;
  acc_t            sum_clip;
  logic            sum_sat;
  logic            ok_a, ok_b, ok_c;
  logic            first_we, second_we, acc_we;
  res_addr_t       acc_waddr;
  acc_t            acc_wdata;
  acc_t            res_value;
  logic            res_err, res_sat;

  // item register and store reads, issued as the word is accepted
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q      <= mode_i;
      ia_q        <= first_index_i;
      ib_q        <= second_index_i;
      ic_q        <= target_index_i;
      val_q       <= load_value_i;
      first_rd_q  <= first_mem[VecAw'(first_index_i)];
      second_rd_q <= second_mem[VecAw'(second_index_i)];
      acc_rd_q    <= acc_mem[ResAw'(target_index_i)];
    end
    if (cmd_i.mul) begin
      prod_q <= first_rd_q * second_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (first_we) begin
      first_mem[VecAw'(ia_q)] <= val_q;
    end
    if (second_we) begin
      second_mem[VecAw'(ia_q)] <= val_q;
    end
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
  end

  always_comb begin
    // floor of q32.32 to q32.16 is the arithmetic shift
    prod_shift = prod_q[2*ValW-1:16];
    sum_wide   = {acc_rd_q[AccW-1], acc_rd_q} + {prod_shift[AccW-1], prod_shift};
    sum_sat    = sum_wide[AccW] ^ sum_wide[AccW-1];
    if (sum_sat) begin
      sum_clip = sum_wide[AccW] ? AccMin : AccMax;
    end else begin
      sum_clip = sum_wide[AccW-1:0];
    end

    ok_a = vec_in_range(ia_q);
    ok_b = vec_in_range(ib_q);
    ok_c = res_in_range(ic_q);

    first_we  = 1'b0;
    second_we = 1'b0;
    acc_we    = 1'b0;
    acc_waddr = ResAw'(ic_q);
    acc_wdata = '0;
    res_value = '0;
    res_err   = 1'b0;
    res_sat   = 1'b0;

    unique case (mode_q)
      MODE_LOAD_FIRST: begin
        first_we = cmd_i.wb && ok_a;
        res_err  = !ok_a;
      end
      MODE_LOAD_SECOND: begin
        second_we = cmd_i.wb && ok_a;
        res_err   = !ok_a;
      end
      MODE_ACCUMULATE: begin
        if (ok_a && ok_b && ok_c) begin
          acc_we    = cmd_i.wb;
          acc_wdata = sum_clip;
          res_sat   = sum_sat;
        end else begin
          res_err = 1'b1;
        end
      end
      MODE_READ: begin
        if (ok_c) begin
          res_value = acc_rd_q;
        end else begin
          res_err = 1'b1;
        end
      end
      MODE_CLEAR: begin
        acc_we  = cmd_i.wb && ok_c;
        res_err = !ok_c;
      end
      default: begin
      end
    endcase

    // clearing pass owns the accumulator write port
    if (cmd_i.clr) begin
      acc_we    = 1'b1;
      acc_waddr = cmd_i.clr_addr;
      acc_wdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.wb) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      out_value_q <= res_value;
      out_err_q   <= res_err;
      out_sat_q   <= res_sat;
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign read_value_o      = out_value_q;
  assign range_error_o     = out_err_q;
  assign saturated_o       = out_sat_q;

endmodule

FILE: rtl/indexed_product_scatter_accumulate_core.sv
// ----------------------------------------------------------------------------
// indexed_product_scatter_accumulate_core
// Gather, multiply and scatter-add engine over two local Q16.16 operand
// stores and one Q32.16 accumulator store, each one word wide per access.
// After reset the core runs a clearing pass over all RESULT_DEPTH (1024)
// words of the accumulator store and accepts no word until it is done.
// Then each input word passes the controller states in order: ST_IDLE
// accepts it and issues the three store reads, ST_MUL registers the 32x32
// product, ST_WB does the saturating add, the store write back and loads
// the output register. The write back waits while the output register still
// holds an untaken word; a new word is accepted while a finished result
// waits downstream. Every input word yields exactly one output word.
// ----------------------------------------------------------------------------
module indexed_product_scatter_accumulate_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // first_index[9:0], second_index[19:10], target_index[29:20],
  // load_value[61:30], zero[63:62]
  input  logic [63:0] s_axis_tdata_i,
  // mode[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_value[47:0]
  output logic [47:0] m_axis_tdata_o,
  // range_error[0], saturated[1]
  output logic [1:0]  m_axis_tuser_o
);
  import ipsa_pkg::*;

  cmd_t    cmd;
  status_t status;
  acc_t    read_value;
  logic    range_error;
  logic    saturated;

  ipsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ipsa_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .mode_i         (mode_e'(s_axis_tuser_i)),
    .first_index_i  (s_axis_tdata_i[9:0]),
    .second_index_i (s_axis_tdata_i[19:10]),
    .target_index_i (s_axis_tdata_i[29:20]),
    .load_value_i   (s_axis_tdata_i[61:30]),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .read_value_o   (read_value),
    .range_error_o  (range_error),
    .saturated_o    (saturated)
  );

  assign m_axis_tdata_o = read_value;
  assign m_axis_tuser_o = {saturated, range_error};

endmodule
